FILE: hdl/grid_maze_path_search_ordered_defines.svh
// ----------------------------------------------------------------------------
// grid maze path search assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef GRID_MAZE_PATH_SEARCH_ORDERED_DEFINES_SVH
`define GRID_MAZE_PATH_SEARCH_ORDERED_DEFINES_SVH

// same-cycle implication
`define GMPS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gmps same-cycle check failed");

// next-cycle implication
`define GMPS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gmps next-cycle check failed");

`endif

FILE: hdl/gmps_pkg.sv
// ----------------------------------------------------------------------------
// gmps_pkg
// types and codes for the grid maze path search block
// ----------------------------------------------------------------------------
package gmps_pkg;

    typedef struct packed {
        logic [31:0] row_cells;
        logic        last_row;
    } gmps_in_t;

    typedef struct packed {
        logic [31:0] path_row;
        logic [4:0]  row_index;
        logic        path_found;
        logic        final_row;
    } gmps_out_t;

    // configuration register indexes
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    // neighbor try order kept in each stack entry
    localparam logic [2:0] DIR_DOWN  = 3'd0;
    localparam logic [2:0] DIR_RIGHT = 3'd1;
    localparam logic [2:0] DIR_UP    = 3'd2;
    localparam logic [2:0] DIR_LEFT  = 3'd3;
    localparam logic [2:0] DIR_DONE  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_ST_RD,
        S_ST_CHK,
        S_TOP_RD,
        S_TOP_CHK,
        S_NB_CHK,
        S_PCLR,
        S_PS_RD,
        S_PS_MRD,
        S_PS_WR,
        S_EM_RD,
        S_EM_OUT
    } gmps_state_t;

endpackage

FILE: hdl/gmps_ram.sv
// ----------------------------------------------------------------------------
// gmps_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module gmps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/grid_maze_path_search_ordered.sv
// ----------------------------------------------------------------------------
// grid_maze_path_search_ordered
// loads a maze row per beat, then finds a path from top-left to bottom-right
// by ordered depth-first backtracking and returns one beat per row
// ----------------------------------------------------------------------------
//  channel   signals                       direction  handshake
//  config    cfg_we cfg_addr cfg_data      in         write on cfg_we
//  maze row  start item busy               in         start && !busy
//  result    res_valid res                 out        one-cycle strobe
//
// a beat without last_row leaves the block idle
// the last row starts the search: the visit marks are cleared (S_CLR), then
//   the start cell is checked (S_ST_RD, S_ST_CHK); each try reads the stack
//   top (S_TOP_RD, S_TOP_CHK), then probes an in-bounds neighbor (S_NB_CHK);
//   a cell gets four tries and one pop, plus at most four probes
// on success the marks are cleared (S_PCLR), each stack cell is marked again
//   as the path mask (S_PS_RD, S_PS_MRD, S_PS_WR), then each row is emitted
// reset clears control state only; the memories hold no reset value
// the receiver cannot stall, so results go out as they are produced
// ----------------------------------------------------------------------------
module grid_maze_path_search_ordered
    import gmps_pkg::*;
#(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_addr,
    input  logic [5:0] cfg_data,
    input  logic      start,
    input  gmps_in_t  item,
    output logic      busy,
    output logic      res_valid,
    output gmps_out_t res
);

    localparam int RIW   = $clog2(MAX_ROWS);
    localparam int CIW   = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int SIW   = $clog2(DEPTH);
    localparam int SPW   = $clog2(DEPTH + 1);
    localparam int SEW   = RIW + CIW + 3;

    // configuration registers
    logic [5:0] num_rows_reg;
    logic [5:0] num_cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= 6'd32;
            num_cols_reg <= 6'd32;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == REG_NUM_ROWS)
            begin
                num_rows_reg <= cfg_data;
            end
            else
            begin
                num_cols_reg <= cfg_data;
            end
        end
    end

    // clamped sizes: zero counts as one, above max counts as max
    logic [RW-1:0] rows;
    logic [CW-1:0] cols;

    always_comb
    begin
        if (num_rows_reg == 6'd0)
            rows = RW'(1);
        else if (7'(num_rows_reg) > 7'(MAX_ROWS))
            rows = RW'(MAX_ROWS);
        else
            rows = RW'(num_rows_reg);
        if (num_cols_reg == 6'd0)
            cols = CW'(1);
        else if (7'(num_cols_reg) > 7'(MAX_COLS))
            cols = CW'(MAX_COLS);
        else
            cols = CW'(num_cols_reg);
    end

    // memories: maze rows, visit marks (later path mask), walk stack
    logic                maze_we;
    logic [RIW-1:0]      maze_waddr;
    logic [MAX_COLS-1:0] maze_wdata;
    logic [RIW-1:0]      maze_raddr;
    logic [MAX_COLS-1:0] maze_q;
    logic                mark_we;
    logic [RIW-1:0]      mark_waddr;
    logic [MAX_COLS-1:0] mark_wdata;
    logic [RIW-1:0]      mark_raddr;
    logic [MAX_COLS-1:0] mark_q;
    logic                stk_we;
    logic [SIW-1:0]      stk_waddr;
    logic [SEW-1:0]      stk_wdata;
    logic [SIW-1:0]      stk_raddr;
    logic [SEW-1:0]      stk_q;

    gmps_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_maze (
        .clk   (clk),
        .we    (maze_we),
        .waddr (maze_waddr),
        .wdata (maze_wdata),
        .raddr (maze_raddr),
        .rdata (maze_q)
    );

    gmps_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_mark (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_q)
    );

    gmps_ram #(.WIDTH(SEW), .DEPTH(DEPTH)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_q)
    );

    // control and datapath registers
    gmps_state_t     state_reg, state_next;
    logic [RW-1:0]   load_cnt_reg, load_cnt_next;
    logic [RIW-1:0]  cnt_reg, cnt_next;
    logic [SPW-1:0]  sp_reg, sp_next;
    logic [SPW-1:0]  ptr_reg, ptr_next;
    logic            found_reg, found_next;
    logic [RIW-1:0]  nb_r_reg, nb_r_next;
    logic [CIW-1:0]  nb_c_reg, nb_c_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            load_cnt_reg <= '0;
            cnt_reg      <= '0;
            sp_reg       <= '0;
            ptr_reg      <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            cnt_reg      <= cnt_next;
            sp_reg       <= sp_next;
            ptr_reg      <= ptr_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nb_r_reg <= nb_r_next;
        nb_c_reg <= nb_c_next;
    end

    // stack top fields
    logic [RIW-1:0] top_r;
    logic [CIW-1:0] top_c;
    logic [2:0]     top_d;
    logic [SPW-1:0] sp_m1;

    assign top_r = stk_q[SEW-1 -: RIW];
    assign top_c = stk_q[CIW+2 : 3];
    assign top_d = stk_q[2:0];
    assign sp_m1 = sp_reg - SPW'(1);

    // neighbor candidate for the current try direction
    logic           nb_ok;
    logic [RIW-1:0] nb_r;
    logic [CIW-1:0] nb_c;

    always_comb
    begin
        nb_ok = 1'b0;
        nb_r  = top_r;
        nb_c  = top_c;
        case (top_d)
            DIR_DOWN:
            begin
                nb_ok = (RW'(top_r) + RW'(1)) < rows;
                nb_r  = top_r + RIW'(1);
            end
            DIR_RIGHT:
            begin
                nb_ok = (CW'(top_c) + CW'(1)) < cols;
                nb_c  = top_c + CIW'(1);
            end
            DIR_UP:
            begin
                nb_ok = top_r != '0;
                nb_r  = top_r - RIW'(1);
            end
            DIR_LEFT:
            begin
                nb_ok = top_c != '0;
                nb_c  = top_c - CIW'(1);
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

    logic nb_usable;
    logic at_goal;
    logic last_clr;
    logic last_emit;

    assign nb_usable = maze_q[nb_c_reg] & ~mark_q[nb_c_reg];
    assign at_goal   = (RW'(nb_r_reg) == rows - RW'(1)) &&
                       (CW'(nb_c_reg) == cols - CW'(1));
    assign last_clr  = cnt_reg == RIW'(MAX_ROWS - 1);
    assign last_emit = RW'(cnt_reg) == rows - RW'(1);

    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        cnt_next      = cnt_reg;
        sp_next       = sp_reg;
        ptr_next      = ptr_reg;
        found_next    = found_reg;
        nb_r_next     = nb_r_reg;
        nb_c_next     = nb_c_reg;
        maze_we       = 1'b0;
        maze_waddr    = load_cnt_reg[RIW-1:0];
        maze_wdata    = MAX_COLS'(item.row_cells);
        maze_raddr    = cnt_reg;
        mark_we       = 1'b0;
        mark_waddr    = cnt_reg;
        mark_wdata    = '0;
        mark_raddr    = cnt_reg;
        stk_we        = 1'b0;
        stk_waddr     = sp_m1[SIW-1:0];
        stk_wdata     = {top_r, top_c, top_d + 3'd1};
        stk_raddr     = sp_m1[SIW-1:0];
        res_valid     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // rows past capacity are dropped
                    if (load_cnt_reg < RW'(MAX_ROWS))
                    begin
                        maze_we       = 1'b1;
                        load_cnt_next = load_cnt_reg + RW'(1);
                    end
                    if (item.last_row)
                    begin
                        load_cnt_next = '0;
                        cnt_next      = '0;
                        found_next    = 1'b0;
                        sp_next       = '0;
                        state_next    = S_CLR;
                    end
                end
            end
            S_CLR:
            begin
                mark_we = 1'b1;
                if (last_clr)
                begin
                    cnt_next   = '0;
                    state_next = S_ST_RD;
                end
                else
                begin
                    cnt_next = cnt_reg + RIW'(1);
                end
            end
            S_ST_RD:
            begin
                maze_raddr = '0;
                state_next = S_ST_CHK;
            end
            S_ST_CHK:
            begin
                if (!maze_q[0])
                begin
                    // closed start
                    cnt_next   = '0;
                    state_next = S_EM_RD;
                end
                else
                begin
                    mark_we    = 1'b1;
                    mark_waddr = '0;
                    mark_wdata = MAX_COLS'(1);
                    stk_we     = 1'b1;
                    stk_waddr  = '0;
                    stk_wdata  = {RIW'(0), CIW'(0), DIR_DOWN};
                    sp_next    = SPW'(1);
                    if (rows == RW'(1) && cols == CW'(1))
                    begin
                        found_next = 1'b1;
                        cnt_next   = '0;
                        state_next = S_PCLR;
                    end
                    else
                    begin
                        state_next = S_TOP_RD;
                    end
                end
            end
            S_TOP_RD:
            begin
                if (sp_reg == '0)
                begin
                    cnt_next   = '0;
                    state_next = S_EM_RD;
                end
                else
                begin
                    state_next = S_TOP_CHK;
                end
            end
            S_TOP_CHK:
            begin
                if (top_d >= DIR_DONE)
                begin
                    sp_next    = sp_m1;
                    state_next = S_TOP_RD;
                end
                else
                begin
                    stk_we = 1'b1;
                    if (nb_ok)
                    begin
                        maze_raddr = nb_r;
                        mark_raddr = nb_r;
                        nb_r_next  = nb_r;
                        nb_c_next  = nb_c;
                        state_next = S_NB_CHK;
                    end
                    else
                    begin
                        state_next = S_TOP_RD;
                    end
                end
            end
            S_NB_CHK:
            begin
                state_next = S_TOP_RD;
                if (nb_usable)
                begin
                    mark_we    = 1'b1;
                    mark_waddr = nb_r_reg;
                    mark_wdata = mark_q | (MAX_COLS'(1) << nb_c_reg);
                    stk_we     = 1'b1;
                    stk_waddr  = sp_reg[SIW-1:0];
                    stk_wdata  = {nb_r_reg, nb_c_reg, DIR_DOWN};
                    sp_next    = sp_reg + SPW'(1);
                    if (at_goal)
                    begin
                        found_next = 1'b1;
                        cnt_next   = '0;
                        state_next = S_PCLR;
                    end
                end
            end
            S_PCLR:
            begin
                mark_we = 1'b1;
                if (last_clr)
                begin
                    cnt_next   = '0;
                    ptr_next   = '0;
                    state_next = S_PS_RD;
                end
                else
                begin
                    cnt_next = cnt_reg + RIW'(1);
                end
            end
            S_PS_RD:
            begin
                stk_raddr = ptr_reg[SIW-1:0];
                if (ptr_reg == sp_reg)
                begin
                    cnt_next   = '0;
                    state_next = S_EM_RD;
                end
                else
                begin
                    state_next = S_PS_MRD;
                end
            end
            S_PS_MRD:
            begin
                mark_raddr = top_r;
                nb_r_next  = top_r;
                nb_c_next  = top_c;
                state_next = S_PS_WR;
            end
            S_PS_WR:
            begin
                mark_we    = 1'b1;
                mark_waddr = nb_r_reg;
                mark_wdata = mark_q | (MAX_COLS'(1) << nb_c_reg);
                ptr_next   = ptr_reg + SPW'(1);
                state_next = S_PS_RD;
            end
            S_EM_RD:
            begin
                state_next = S_EM_OUT;
            end
            S_EM_OUT:
            begin
                res_valid = 1'b1;
                if (last_emit)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + RIW'(1);
                    state_next = S_EM_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result row: path mask or stored maze, limited to the columns in use
    logic [MAX_COLS-1:0] col_mask;
    logic [MAX_COLS-1:0] row_bits;

    always_comb
    begin
        for (int j = 0; j < MAX_COLS; j++)
        begin
            col_mask[j] = CW'(j) < cols;
        end
    end

    assign row_bits = (found_reg ? mark_q : maze_q) & col_mask;

    assign busy           = state_reg != S_IDLE;
    assign res.path_row   = 32'(row_bits);
    assign res.row_index  = 5'(cnt_reg);
    assign res.path_found = found_reg;
    assign res.final_row  = last_emit;

endmodule

FILE: hdl/gmps_checker.sv
// ----------------------------------------------------------------------------
// gmps_checker
// port-level checks for the grid maze path search block
// ----------------------------------------------------------------------------
`include "grid_maze_path_search_ordered_defines.svh"

module gmps_checker
    import gmps_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input gmps_in_t  item,
    input logic      busy,
    input logic      res_valid,
    input gmps_out_t res
);

    // results only come out during a run
    `GMPS_ASSERT_IMP(a_res_in_run, res_valid, busy)

    // the last row beat starts a run
    `GMPS_ASSERT_NXT(a_last_starts, start && !busy && item.last_row, busy)

    // the final result beat ends the run
    `GMPS_ASSERT_NXT(a_final_ends, res_valid && res.final_row, !busy)

    // result beats never come back to back, and the run stays busy between them
    `GMPS_ASSERT_NXT(a_res_spaced, res_valid && !res.final_row, !res_valid && busy)

endmodule

bind grid_maze_path_search_ordered gmps_checker u_gmps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res)
);
